### hdl/mtp_pkg.sv
package mtp_pkg;

  localparam int unsigned CH_W      = 8;
  localparam int unsigned ADDR_W    = 48;
  localparam int unsigned NUM_BYTES = 6;
  localparam int unsigned MIN_CHARS = 17;

  localparam logic [7:0] CH_TERM  = 8'h00;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef struct packed {
    logic [ADDR_W-1:0] mac_address;
    logic              valid_res;
  } mtp_res_t;

  typedef struct packed {
    logic       is_hex;
    logic [3:0] value;
  } mtp_hex_t;

  // Decodes one ASCII hex digit in either case.
  function automatic mtp_hex_t hex_decode(input logic [CH_W-1:0] c);
    mtp_hex_t h;
    h.is_hex = 1'b1;
    h.value  = 4'd0;
    case (c) inside
      [8'h30:8'h39]: h.value = c[3:0];
      [8'h41:8'h46],
      [8'h61:8'h66]: h.value = 4'(c[2:0] + 4'd9);
      default:       h.is_hex = 1'b0;
    endcase
    return h;
  endfunction

endpackage

### hdl/mtp_ifs.sv
interface mtp_char_if import mtp_pkg::*; ();
  logic            valid;
  logic            ready;
  logic [CH_W-1:0] ch;

  modport source (output valid, output ch, input ready);
  modport sink   (input valid, input ch, output ready);
endinterface

interface mtp_res_if import mtp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] mac_address;
  logic              valid_res;

  modport source (output valid, output mac_address, output valid_res, input ready);
  modport sink   (input valid, input mac_address, input valid_res, output ready);
endinterface

### hdl/mac_address_text_parser.sv
// Parses a MAC address written as ASCII text, one character per item, at one
// item per clock cycle while the input is not stalled: each character updates
// the parse state in the cycle it is accepted. Hex digits in either case build
// a byte, which ends after two digits or at a colon; a colon right after a
// two-digit byte is a plain separator. Only the zero terminator yields a result
// item: the 48-bit address (first text byte in bits 47..40) with valid_res
// set, or zero with valid_res clear if the text held an illegal character,
// more than six bytes, or fewer than 17 characters. The parser then starts
// afresh for the next string. A result register with one skid entry keeps
// input flowing while results wait; input stalls only when both hold an
// undelivered result.
module mac_address_text_parser import mtp_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  mtp_char_if.sink  in_chan,
  mtp_res_if.source out_chan
);

  localparam int unsigned IDX_W = $clog2(NUM_BYTES + 1);
  localparam int unsigned CNT_W = $clog2(MIN_CHARS + 1);

  logic [ADDR_W-1:0] addr_r,    addr_nxt;
  logic [IDX_W-1:0]  byte_idx_r, byte_idx_nxt;
  logic              half_r,    half_nxt;
  logic [7:0]        part_r,    part_nxt;
  logic              sep_ok_r,  sep_ok_nxt;
  logic [CNT_W-1:0]  char_cnt_r, char_cnt_nxt;
  logic              failed_r,  failed_nxt;

  mtp_res_t  out_data_r, skid_data_r, res_new;
  logic      out_valid_r, skid_valid_r;
  logic      accept, push, pop;
  mtp_hex_t  hex;
  logic [ADDR_W-1:0] addr_final;

  assign in_chan.ready = !skid_valid_r;
  assign accept        = in_chan.valid && in_chan.ready;
  assign push          = accept && (in_chan.ch == CH_TERM);
  assign pop           = out_valid_r && out_chan.ready;
  assign hex           = hex_decode(in_chan.ch);

  // Places a completed byte into its lane; lanes not yet reached are still zero.
  function automatic logic [ADDR_W-1:0] store_lane(input logic [ADDR_W-1:0] a,
                                                   input logic [IDX_W-1:0]  idx,
                                                   input logic [7:0]        b);
    logic [ADDR_W-1:0] r;
    r = a;
    for (int k = 0; k < NUM_BYTES; k++) begin
      if (idx == IDX_W'(k)) begin
        r[8*(NUM_BYTES-1-k) +: 8] = b;
      end
    end
    return r;
  endfunction

  always_comb begin
    addr_final = addr_r;
    if (!failed_r && byte_idx_r < IDX_W'(NUM_BYTES)) begin
      addr_final = store_lane(addr_r, byte_idx_r, part_r);
    end
    res_new.valid_res   = !failed_r && (char_cnt_r >= CNT_W'(MIN_CHARS));
    res_new.mac_address = res_new.valid_res ? addr_final : '0;
  end

  always_comb begin
    addr_nxt     = addr_r;
    byte_idx_nxt = byte_idx_r;
    half_nxt     = half_r;
    part_nxt     = part_r;
    sep_ok_nxt   = sep_ok_r;
    char_cnt_nxt = char_cnt_r;
    failed_nxt   = failed_r;
    if (accept) begin
      if (in_chan.ch == CH_TERM) begin
        addr_nxt     = '0;
        byte_idx_nxt = '0;
        half_nxt     = 1'b0;
        part_nxt     = '0;
        sep_ok_nxt   = 1'b1;
        char_cnt_nxt = '0;
        failed_nxt   = 1'b0;
      end else begin
        if (char_cnt_r < CNT_W'(MIN_CHARS)) begin
          char_cnt_nxt = char_cnt_r + CNT_W'(1);
        end
        if (!failed_r) begin
          if (byte_idx_r >= IDX_W'(NUM_BYTES)) begin
            failed_nxt = 1'b1;
          end else if (hex.is_hex) begin
            if (half_r) begin
              addr_nxt     = store_lane(addr_r, byte_idx_r, {part_r[3:0], hex.value});
              byte_idx_nxt = byte_idx_r + IDX_W'(1);
              half_nxt     = 1'b0;
              part_nxt     = '0;
              sep_ok_nxt   = 1'b0;
            end else begin
              part_nxt   = {part_r[3:0], hex.value};
              half_nxt   = 1'b1;
              sep_ok_nxt = 1'b1;
            end
          end else if (in_chan.ch == CH_COLON) begin
            // A colon ends the byte, even an empty one, unless it follows a full byte.
            if (sep_ok_r) begin
              addr_nxt     = store_lane(addr_r, byte_idx_r, part_r);
              byte_idx_nxt = byte_idx_r + IDX_W'(1);
              half_nxt     = 1'b0;
              part_nxt     = '0;
            end
            sep_ok_nxt = 1'b1;
          end else begin
            failed_nxt = 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r     <= '0;
      byte_idx_r <= '0;
      half_r     <= 1'b0;
      part_r     <= '0;
      sep_ok_r   <= 1'b1;
      char_cnt_r <= '0;
      failed_r   <= 1'b0;
    end else begin
      addr_r     <= addr_nxt;
      byte_idx_r <= byte_idx_nxt;
      half_r     <= half_nxt;
      part_r     <= part_nxt;
      sep_ok_r   <= sep_ok_nxt;
      char_cnt_r <= char_cnt_nxt;
      failed_r   <= failed_nxt;
    end
  end

  // Result register with one skid entry behind it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        out_valid_r  <= 1'b1;
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_valid_r <= 1'b1;
      end else begin
        skid_valid_r <= 1'b1;
      end
    end else if (pop) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (push) begin
      if (!out_valid_r || pop) begin
        out_data_r <= res_new;
      end else begin
        skid_data_r <= res_new;
      end
    end
  end

  assign out_chan.valid       = out_valid_r;
  assign out_chan.mac_address = out_data_r.mac_address;
  assign out_chan.valid_res   = out_data_r.valid_res;

`ifndef SYNTHESIS
  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry holds a result while the output register is empty");

  a_byte_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_idx_r <= IDX_W'(NUM_BYTES))
    else $error("byte index past the last byte");

  a_char_cnt_sat: assert property (@(posedge clk) disable iff (!rst_n)
    char_cnt_r <= CNT_W'(MIN_CHARS))
    else $error("character count past saturation");

  a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_data_r.valid_res) |-> (out_data_r.mac_address == '0))
    else $error("rejected result carries a nonzero address");

  a_term_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> (byte_idx_r == '0 && char_cnt_r == '0 && !failed_r && sep_ok_r))
    else $error("parser did not restart after a terminator");
`endif

endmodule

### bench/mac_address_text_parser_tb.sv
module mac_address_text_parser_tb;
  import mtp_pkg::*;

  typedef logic [CH_W-1:0] text_q_t[$];

  typedef struct {
    string       text;
    bit          known;
    logic [47:0] mac;
    logic        ok;
  } dir_row_t;

  localparam int NUM_ROWS = 20;
  localparam int RANDOM_CHARS = 1010;
  localparam int PRESSURE_FIRST = 6;
  localparam int PRESSURE_LAST = 11;
  localparam int HOLD_OFF_CYCLES = 150;
  localparam int DRAIN_LIMIT = 100000;
  localparam int SETTLE_CYCLES = 10;

  // Rows with a known result carry it; the others are checked by the parser model.
  dir_row_t dir_rows [NUM_ROWS] = '{
    '{"", 1'b1, 48'h0, 1'b0},
    '{"00:00:00:00:00:00", 1'b1, 48'h0, 1'b1},
    '{"FF:FF:FF:FF:FF:FF", 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1},
    '{"ff:ff:ff:ff:ff:ff", 1'b1, 48'hFFFF_FFFF_FFFF, 1'b1},
    '{"01:23:45:67:89:ab", 1'b1, 48'h0123_4567_89AB, 1'b1},
    '{"Cd:eF:aB:9c:D0:e1", 1'b0, 48'h0, 1'b0},
    '{"0123456789abcdef0", 1'b1, 48'h0, 1'b0},
    '{"01:23:45:67:89:AB:", 1'b1, 48'h0, 1'b0},
    '{"01:23:45:67:89:AB7", 1'b1, 48'h0, 1'b0},
    '{"01::23:45:67:89:AB", 1'b0, 48'h0, 1'b0},
    '{":1:2:3:4:5", 1'b0, 48'h0, 1'b0},
    '{"01:23:45:67:89:a", 1'b0, 48'h0, 1'b0},
    '{"1:2:3:4:5:6", 1'b1, 48'h0, 1'b0},
    '{"/0:12:34:56:78:9A", 1'b1, 48'h0, 1'b0},
    '{"@0:12:34:56:78:9A", 1'b1, 48'h0, 1'b0},
    '{"G0:12:34:56:78:9A", 1'b1, 48'h0, 1'b0},
    '{"0\140:12:34:56:78:9g", 1'b1, 48'h0, 1'b0},
    '{"01-23-45-67-89-AB", 1'b1, 48'h0, 1'b0},
    '{"zzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzzz", 1'b1, 48'h0, 1'b0},
    '{"\377", 1'b1, 48'h0, 1'b0}
  };

  typedef struct {
    logic [47:0] addr;
    logic [2:0]  nbytes;
    logic [1:0]  ndigits;
    logic [7:0]  cur;
    logic        sep_ok;
    logic [4:0]  nchars;
    logic        bad;
  } parser_state_t;

  logic clk;
  logic rst_n;

  mtp_char_if char_chan ();
  mtp_res_if  res_chan ();

  mac_address_text_parser dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (char_chan.sink),
    .out_chan (res_chan.source)
  );

  parser_state_t parser;
  mtp_res_t      pending_results[$];
  int            mismatches = 0;
  int            src_idle_pct = 0;
  int            sink_idle_pct = 0;
  bit            hold_off_req = 1'b0;
  bit            known_result = 1'b0;
  mtp_res_t      known_res;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("mac_address_text_parser_tb: FAIL");
    $finish;
  end

  function automatic void clear_parser();
    parser.addr    = '0;
    parser.nbytes  = '0;
    parser.ndigits = '0;
    parser.cur     = '0;
    parser.sep_ok  = 1'b1;
    parser.nchars  = '0;
    parser.bad     = 1'b0;
  endfunction

  function automatic void commit_byte();
    if (parser.nbytes < NUM_BYTES) begin
      parser.addr = parser.addr |
                    (ADDR_W'(parser.cur) << (8 * (NUM_BYTES - 1 - parser.nbytes)));
      parser.nbytes = parser.nbytes + 3'd1;
    end
    parser.ndigits = '0;
    parser.cur     = '0;
  endfunction

  // Advances the parser by one character; returns 1 when a result comes out.
  function automatic bit parse_char(input logic [CH_W-1:0] c, output mtp_res_t res);
    logic [3:0] nibble;
    bit         is_hex;
    res    = '0;
    is_hex = 1'b1;
    nibble = '0;
    if (c == CH_TERM) begin
      if (!parser.bad && parser.nbytes < NUM_BYTES)
        commit_byte();
      if (!parser.bad && parser.nchars >= MIN_CHARS) begin
        res.mac_address = parser.addr;
        res.valid_res   = 1'b1;
      end
      clear_parser();
      return 1'b1;
    end
    if (parser.nchars < MIN_CHARS)
      parser.nchars = parser.nchars + 5'd1;
    if (parser.bad)
      return 1'b0;
    if (parser.nbytes >= NUM_BYTES) begin
      parser.bad = 1'b1;
      return 1'b0;
    end
    if (c >= "0" && c <= "9")
      nibble = 4'(c - "0");
    else if (c >= "A" && c <= "F")
      nibble = 4'(c - "A" + 8'd10);
    else if (c >= "a" && c <= "f")
      nibble = 4'(c - "a" + 8'd10);
    else
      is_hex = 1'b0;
    if (is_hex) begin
      parser.cur     = {parser.cur[3:0], nibble};
      parser.ndigits = parser.ndigits + 2'd1;
      parser.sep_ok  = 1'b1;
      if (parser.ndigits >= 2) begin
        commit_byte();
        parser.sep_ok = 1'b0;
      end
    end else if (c == CH_COLON) begin
      if (parser.sep_ok)
        commit_byte();
      parser.sep_ok = 1'b1;
    end else begin
      parser.bad = 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85)
      return $urandom_range(1, 3);
    else if (r < 97)
      return $urandom_range(4, 12);
    else
      return $urandom_range(20, 60);
  endfunction

  function automatic int pick_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 10;
      2: return 30;
      default: return 60;
    endcase
  endfunction

  function automatic logic [CH_W-1:0] hex_char(input logic [3:0] v, input bit upper);
    if (v < 10)
      return "0" + 8'(v);
    else if (upper)
      return "A" + 8'(v) - 8'd10;
    else
      return "a" + 8'(v) - 8'd10;
  endfunction

  function automatic logic [CH_W-1:0] noise_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40)
      return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
    else if (r < 55)
      return CH_COLON;
    else
      return 8'($urandom_range(1, 255));
  endfunction

  // Mostly well-formed addresses with random digits and case, then a share of
  // damaged ones and plain noise.
  function automatic text_q_t random_text();
    text_q_t t;
    int      kind;
    int      n;
    kind = $urandom_range(0, 99);
    for (int b = 0; b < NUM_BYTES; b++) begin
      if (b != 0)
        t.push_back(CH_COLON);
      t.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
      t.push_back(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
    end
    if (kind < 60) begin
    end else if (kind < 70) begin
      t[$urandom_range(0, t.size() - 1)] = 8'($urandom_range(1, 255));
    end else if (kind < 77) begin
      n = $urandom_range(0, 16);
      while (t.size() > n)
        void'(t.pop_back());
    end else if (kind < 84) begin
      n = $urandom_range(1, 4);
      repeat (n) t.push_back(noise_char());
    end else if (kind < 90) begin
      t.delete(3 * $urandom_range(0, 4) + 2);
    end else begin
      t.delete();
      n = $urandom_range(0, 40);
      repeat (n) t.push_back(noise_char());
    end
    return t;
  endfunction

  task automatic send_char(input logic [CH_W-1:0] c);
    if ($urandom_range(0, 99) < src_idle_pct) begin
      char_chan.valid = 1'b0;
      repeat (pick_gap()) @(negedge clk);
    end
    char_chan.valid = 1'b1;
    char_chan.ch    = c;
    @(posedge clk);
    while (!char_chan.ready)
      @(posedge clk);
    @(negedge clk);
  endtask

  // Sends the text followed by its zero terminator.
  task automatic send_text(input text_q_t t);
    foreach (t[i])
      send_char(t[i]);
    send_char(CH_TERM);
  endtask

  always @(posedge clk) begin : scoreboard
    mtp_res_t predicted;
    mtp_res_t want;
    if (rst_n) begin
      if (char_chan.valid && char_chan.ready) begin
        if (parse_char(char_chan.ch, predicted))
          pending_results.push_back(known_result ? known_res : predicted);
      end
      if (res_chan.valid && res_chan.ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: unexpected result item mac_address %h valid_res %b", $time,
                   res_chan.mac_address, res_chan.valid_res);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          if (res_chan.mac_address !== want.mac_address) begin
            $display("%0t: mac_address expected %h actual %h", $time,
                     want.mac_address, res_chan.mac_address);
            mismatches++;
          end
          if (res_chan.valid_res !== want.valid_res) begin
            $display("%0t: valid_res expected %b actual %b", $time,
                     want.valid_res, res_chan.valid_res);
            mismatches++;
          end
        end
      end
    end
  end

  // Result side: random stalls, plus one long hold-off on request so the
  // parser fills up and pushes back on its input.
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    res_chan.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (hold_off_req) begin
        stall_left   = HOLD_OFF_CYCLES;
        hold_off_req = 1'b0;
      end else if (stall_left == 0 && $urandom_range(0, 99) < sink_idle_pct) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        res_chan.ready = 1'b0;
        stall_left--;
      end else begin
        res_chan.ready = 1'b1;
      end
    end
  end

  initial begin : stimulus
    text_q_t t;
    int      chars_sent;
    int      nstr;
    int      guard;
    char_chan.valid = 1'b0;
    char_chan.ch    = '0;
    rst_n           = 1'b0;
    known_res       = '0;
    clear_parser();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < NUM_ROWS; i++) begin
      src_idle_pct  = pick_idle_pct();
      sink_idle_pct = pick_idle_pct();
      known_result  = dir_rows[i].known;
      known_res.mac_address = dir_rows[i].mac;
      known_res.valid_res   = dir_rows[i].ok;
      t.delete();
      for (int j = 0; j < dir_rows[i].text.len(); j++)
        t.push_back(dir_rows[i].text[j]);
      send_text(t);
    end
    known_result = 1'b0;

    chars_sent = 0;
    nstr = 0;
    while (chars_sent < RANDOM_CHARS) begin
      if (nstr == PRESSURE_FIRST)
        hold_off_req = 1'b1;
      if (nstr >= PRESSURE_FIRST && nstr <= PRESSURE_LAST) begin
        src_idle_pct = 0;
      end else begin
        src_idle_pct  = pick_idle_pct();
        sink_idle_pct = pick_idle_pct();
      end
      t = random_text();
      send_text(t);
      chars_sent += t.size() + 1;
      nstr++;
    end
    char_chan.valid = 1'b0;

    guard = 0;
    while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (pending_results.size() == 0 && mismatches == 0) begin
      $display("mac_address_text_parser_tb: PASS");
    end else begin
      if (pending_results.size() != 0)
        $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      $display("mac_address_text_parser_tb: FAIL");
    end
    $finish;
  end

endmodule

### files.f
hdl/mtp_pkg.sv
hdl/mtp_ifs.sv
hdl/mac_address_text_parser.sv
bench/mac_address_text_parser_tb.sv
